/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, held off during reset
`define RCI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in one cycle implies an expression in the next
`define RCI_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* src/rci_pkg.sv */
package rci_pkg;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_CENTRE_X  = 3'd0;
	localparam logic [2:0] REG_CENTRE_Y  = 3'd1;
	localparam logic [2:0] REG_RADIUS    = 3'd2;
	localparam logic [2:0] REG_IS_SOURCE = 3'd3;
	localparam logic [2:0] REG_IGN_SRC   = 3'd4;

	localparam int SQRT_BITS = 32;
	localparam int QUO_BITS  = 17;

	localparam logic [30:0]        RADIUS_RST = 31'd65536;
	localparam logic signed [17:0] NORM_ONE   = 18'sd65536;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		logic               src;
		logic               ign;
	} cfg_t;

	// classified ray handed from the front to the back
	typedef struct packed {
		logic               miss;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic [34:0]        adj;
		logic [62:0]        v;
	} qitem_t;

endpackage

/* src/ray_circle_intersect_2d.sv */
// throughput: one ray per cycle while the queue has room, set by the fully pipelined square root and divider
// the square root (32 stages) and the radius divider (17 stages) dominate the latency
// reset (arst_n low) clears all pipeline valids and the queue and loads the
// register reset values: centre 0,0, radius 1.0, not a source, sources counted
module ray_circle_intersect_2d #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// input rays
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // origin_x, origin_y, dir_x, dir_y, zero pad
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // distance, point_x, point_y, normal_x, normal_y, zero pad
	output logic [1:0]   m_tuser,   // hit, hit_kind
	// register writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	rci_pkg::cfg_t   cfg_q;
	rci_pkg::qitem_t f_item, q_item;
	logic            f_push, q_full, q_nonempty, q_pop;

	logic               hit, hit_kind;
	logic [30:0]        distance;
	logic signed [31:0] point_x, point_y;
	logic signed [17:0] normal_x, normal_y;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cx  <= '0;
			cfg_q.cy  <= '0;
			cfg_q.r   <= rci_pkg::RADIUS_RST;
			cfg_q.src <= 1'b0;
			cfg_q.ign <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rci_pkg::REG_CENTRE_X:  cfg_q.cx  <= cfg_data;
				rci_pkg::REG_CENTRE_Y:  cfg_q.cy  <= cfg_data;
				rci_pkg::REG_RADIUS:    cfg_q.r   <= cfg_data[30:0];
				rci_pkg::REG_IS_SOURCE: cfg_q.src <= cfg_data[0];
				rci_pkg::REG_IGN_SRC:   cfg_q.ign <= cfg_data[0];
				default: begin
					// unmapped index, transfer dropped
				end
			endcase
		end
	end

	// front: centre offset, projections, inside and miss tests, half-chord square
	rci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.origin_x (s_tdata[31:0]),
		.origin_y (s_tdata[63:32]),
		.dir_x    (s_tdata[81:64]),
		.dir_y    (s_tdata[99:82]),
		.q_full   (q_full),
		.push     (f_push),
		.item     (f_item)
	);

	// queue decouples front stalls from output back-pressure
	rci_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wr_item  (f_item),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.rd_item  (q_item)
	);

	// back: square root, hit point, normal by division, result register
	rci_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.q_item     (q_item),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hit        (hit),
		.distance   (distance),
		.point_x    (point_x),
		.point_y    (point_y),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.hit_kind   (hit_kind)
	);

	assign m_tdata = {5'b0, normal_y, normal_x, point_y, point_x, distance};
	assign m_tuser = {hit_kind, hit};

endmodule

/* src/rci_queue.sv */
module rci_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rci_pkg::qitem_t wr_item,
	output logic            full,
	output logic            nonempty,
	input  logic            pop,
	output rci_pkg::qitem_t rd_item
);
	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rci_pkg::qitem_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	`RCI_ASSERT(no_overflow, push |-> !full, "queue written while full")
	`RCI_ASSERT(no_underflow, pop |-> nonempty, "queue read while empty")
	`RCI_ASSERT_NEXT(fill_kept, push && !pop, count_q != '0, "queue lost an entry")

endmodule

/* src/rci_front.sv */
module rci_front (
	input  logic               clk,
	input  logic               arst_n,
	input  rci_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic               q_full,
	output logic               push,
	output rci_pkg::qitem_t    item
);

	logic fe;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0] ox_s1, oy_s1, ox_s2, oy_s2, ox_s3, oy_s3, ox_s4, oy_s4;
	logic signed [17:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3, dx_s4, dy_s4;
	logic signed [32:0] ocx_s1, ocy_s1;
	logic signed [50:0] px_s2, py_s2, qx_s2, qy_s2;
	logic [61:0]        sx_s2, sy_s2, rr_s2;
	logic               ltx_s2, lty_s2;
	logic signed [51:0] adjq_s3, perq_s3;
	logic               inside_s3;
	logic               miss_s4;
	logic [34:0]        adj_s4;
	logic [30:0]        rm_s4;
	logic [31:0]        rp_s4;
	rci_pkg::qitem_t    item_s5;

	logic [32:0] ax, ay;
	logic [51:0] pa;
	logic [50:0] adj_rnd, p_rnd;
	logic [34:0] p35;
	logic [30:0] pc;

	// front stalls only when its last stage cannot enter the queue
	assign fe       = !(vld_s5 && q_full);
	assign in_ready = fe;
	assign push     = vld_s5 && !q_full;
	assign item     = item_s5;

	always_comb begin
		ax      = ocx_s1[32] ? 33'(-ocx_s1) : 33'(ocx_s1);
		ay      = ocy_s1[32] ? 33'(-ocy_s1) : 33'(ocy_s1);
		pa      = perq_s3[51] ? 52'(-perq_s3) : 52'(perq_s3);
		adj_rnd = adjq_s3[50:0] + 51'd32768;
		p_rnd   = pa[50:0] + 51'd32768;
		p35     = p_rnd[50:16];
		pc      = (p35 > {4'b0, cfg.r}) ? cfg.r : p35[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (fe) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			// centre offset
			ox_s1  <= origin_x;
			oy_s1  <= origin_y;
			dx_s1  <= dir_x;
			dy_s1  <= dir_y;
			ocx_s1 <= {cfg.cx[31], cfg.cx} - {origin_x[31], origin_x};
			ocy_s1 <= {cfg.cy[31], cfg.cy} - {origin_y[31], origin_y};
			// products
			ox_s2  <= ox_s1;
			oy_s2  <= oy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			px_s2  <= dx_s1 * ocx_s1;
			py_s2  <= dy_s1 * ocy_s1;
			qx_s2  <= dx_s1 * ocy_s1;
			qy_s2  <= dy_s1 * ocx_s1;
			sx_s2  <= ax[30:0] * ax[30:0];
			sy_s2  <= ay[30:0] * ay[30:0];
			rr_s2  <= cfg.r * cfg.r;
			ltx_s2 <= ax < {2'b0, cfg.r};
			lty_s2 <= ay < {2'b0, cfg.r};
			// projection, perpendicular, inside test
			ox_s3     <= ox_s2;
			oy_s3     <= oy_s2;
			dx_s3     <= dx_s2;
			dy_s3     <= dy_s2;
			adjq_s3   <= {px_s2[50], px_s2} + {py_s2[50], py_s2};
			perq_s3   <= {qx_s2[50], qx_s2} - {qy_s2[50], qy_s2};
			inside_s3 <= ltx_s2 && lty_s2 &&
				(({1'b0, sx_s2} + {1'b0, sy_s2}) < {1'b0, rr_s2});
			// classify and round to q16.16
			ox_s4   <= ox_s3;
			oy_s4   <= oy_s3;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			miss_s4 <= (cfg.ign && cfg.src) || inside_s3 ||
				adjq_s3[51] || (adjq_s3 == '0) ||
				(pa > {5'b0, cfg.r, 16'b0});
			adj_s4  <= adj_rnd[50:16];
			rm_s4   <= cfg.r - pc;
			rp_s4   <= {1'b0, cfg.r} + {1'b0, pc};
			// half-chord squared
			item_s5.miss <= miss_s4;
			item_s5.ox   <= ox_s4;
			item_s5.oy   <= oy_s4;
			item_s5.dx   <= dx_s4;
			item_s5.dy   <= dy_s4;
			item_s5.adj  <= adj_s4;
			item_s5.v    <= rm_s4 * rp_s4;
		end
	end

endmodule

/* src/rci_back.sv */
module rci_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rci_pkg::cfg_t      cfg,
	input  logic               q_nonempty,
	input  rci_pkg::qitem_t    q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [30:0]        distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic               hit_kind
);
	`include "assert_macros.svh"

	localparam int SB = rci_pkg::SQRT_BITS;
	localparam int QB = rci_pkg::QUO_BITS;

	typedef struct packed {
		logic               miss;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic [34:0]        adj;
		logic [62:0]        rem;
		logic [31:0]        root;
	} sq_t;

	typedef struct packed {
		logic               miss;
		logic [30:0]        dist_sat;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               negx;
		logic               negy;
		logic               bigx;
		logic               bigy;
		logic               rz;
		logic [32:0]        remx;
		logic [32:0]        remy;
		logic [QB-1:0]      qx;
		logic [QB-1:0]      qy;
	} dv_t;

	logic be;

	sq_t         sq_s [SB+1];
	sq_t         sq_nx [SB];
	logic [63:0] sq_d [SB];
	logic [SB:0] sq_vld_s;

	logic               vld_sl, vld_sm, vld_sr;
	logic               miss_sl, miss_sm, miss_sr;
	logic [34:0]        len_sl, len_sm, len_sr;
	logic signed [31:0] ox_sl, oy_sl, ox_sm, oy_sm;
	logic signed [17:0] dx_sl, dy_sl;
	logic signed [53:0] mx_sm, my_sm;
	logic signed [38:0] hx_sr, hy_sr;

	dv_t         dv_s [QB+1];
	dv_t         dv_nx [QB];
	logic [QB:0] dv_vld_s;

	logic signed [53:0] mxr, myr;
	logic signed [39:0] ex, ey;
	logic [39:0]        numx, numy;
	logic [16:0]        magx, magy;
	dv_t                dv_in;

	logic               out_vld_q, hit_q, kind_q;
	logic [30:0]        dist_q;
	logic signed [31:0] ptx_q, pty_q;
	logic signed [17:0] nx_q, ny_q;

	logic               res_zero, norm_ok;

	assign be        = !(out_vld_q && !out_ready);
	assign pop       = q_nonempty && be;
	assign out_valid = out_vld_q;
	assign hit       = hit_q;
	assign distance  = dist_q;
	assign point_x   = ptx_q;
	assign point_y   = pty_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign hit_kind  = kind_q;

	// square root, one result bit per stage
	always_comb begin
		for (int j = 0; j < SB; j++) begin
			sq_d[j]  = ({32'b0, sq_s[j].root} << (SB - j)) |
				(64'd1 << (2 * (SB - 1 - j)));
			sq_nx[j] = sq_s[j];
			if ({1'b0, sq_s[j].rem} >= sq_d[j]) begin
				sq_nx[j].rem  = sq_s[j].rem - sq_d[j][62:0];
				sq_nx[j].root = sq_s[j].root | (32'd1 << (SB - 1 - j));
			end
		end
	end

	// hit point, offset from centre, divider set-up
	always_comb begin
		mxr  = mx_sm + 54'sd32768;
		myr  = my_sm + 54'sd32768;
		ex   = {hx_sr[38], hx_sr} - {{8{cfg.cx[31]}}, cfg.cx};
		ey   = {hy_sr[38], hy_sr} - {{8{cfg.cy[31]}}, cfg.cy};
		numx = ex[39] ? 40'(-ex) : 40'(ex);
		numy = ey[39] ? 40'(-ey) : 40'(ey);
		dv_in.miss = miss_sr;
		dv_in.dist_sat = (len_sr[34:31] != '0) ? '1 : len_sr[30:0];
		if (hx_sr[38:31] == '0 || hx_sr[38:31] == '1) begin
			dv_in.px = hx_sr[31:0];
		end else begin
			dv_in.px = hx_sr[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		if (hy_sr[38:31] == '0 || hy_sr[38:31] == '1) begin
			dv_in.py = hy_sr[31:0];
		end else begin
			dv_in.py = hy_sr[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		dv_in.negx = ex[39];
		dv_in.negy = ey[39];
		dv_in.bigx = numx >= {8'b0, cfg.r, 1'b0};
		dv_in.bigy = numy >= {8'b0, cfg.r, 1'b0};
		dv_in.rz   = (cfg.r == '0);
		dv_in.remx = numx[32:0];
		dv_in.remy = numy[32:0];
		dv_in.qx   = '0;
		dv_in.qy   = '0;
	end

	// restoring division by the radius, one quotient bit per stage
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			dv_nx[j] = dv_s[j];
			if (dv_s[j].remx >= {2'b0, cfg.r}) begin
				dv_nx[j].remx = (dv_s[j].remx - {2'b0, cfg.r}) << 1;
				dv_nx[j].qx   = dv_s[j].qx | (QB'(1) << (QB - 1 - j));
			end else begin
				dv_nx[j].remx = dv_s[j].remx << 1;
			end
			if (dv_s[j].remy >= {2'b0, cfg.r}) begin
				dv_nx[j].remy = (dv_s[j].remy - {2'b0, cfg.r}) << 1;
				dv_nx[j].qy   = dv_s[j].qy | (QB'(1) << (QB - 1 - j));
			end else begin
				dv_nx[j].remy = dv_s[j].remy << 1;
			end
		end
		magx = dv_s[QB].bigx ? 17'd65536 :
			((dv_s[QB].qx > 17'd65536) ? 17'd65536 : dv_s[QB].qx);
		magy = dv_s[QB].bigy ? 17'd65536 :
			((dv_s[QB].qy > 17'd65536) ? 17'd65536 : dv_s[QB].qy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s  <= '0;
			vld_sl    <= 1'b0;
			vld_sm    <= 1'b0;
			vld_sr    <= 1'b0;
			dv_vld_s  <= '0;
			out_vld_q <= 1'b0;
		end else if (be) begin
			sq_vld_s  <= {sq_vld_s[SB-1:0], pop};
			vld_sl    <= sq_vld_s[SB];
			vld_sm    <= vld_sl;
			vld_sr    <= vld_sm;
			dv_vld_s  <= {dv_vld_s[QB-1:0], vld_sr};
			out_vld_q <= dv_vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			sq_s[0].miss <= q_item.miss;
			sq_s[0].ox   <= q_item.ox;
			sq_s[0].oy   <= q_item.oy;
			sq_s[0].dx   <= q_item.dx;
			sq_s[0].dy   <= q_item.dy;
			sq_s[0].adj  <= q_item.adj;
			sq_s[0].rem  <= q_item.v;
			sq_s[0].root <= '0;
			for (int j = 0; j < SB; j++) begin
				sq_s[j+1] <= sq_nx[j];
			end
			// distance, floored at zero
			miss_sl <= sq_s[SB].miss;
			ox_sl   <= sq_s[SB].ox;
			oy_sl   <= sq_s[SB].oy;
			dx_sl   <= sq_s[SB].dx;
			dy_sl   <= sq_s[SB].dy;
			len_sl  <= (sq_s[SB].adj > {3'b0, sq_s[SB].root}) ?
				sq_s[SB].adj - {3'b0, sq_s[SB].root} : '0;
			// step along the ray
			miss_sm <= miss_sl;
			len_sm  <= len_sl;
			ox_sm   <= ox_sl;
			oy_sm   <= oy_sl;
			mx_sm   <= $signed({1'b0, len_sl}) * dx_sl;
			my_sm   <= $signed({1'b0, len_sl}) * dy_sl;
			// rounded hit point
			miss_sr <= miss_sm;
			len_sr  <= len_sm;
			hx_sr   <= {{7{ox_sm[31]}}, ox_sm} + {mxr[53], mxr[53:16]};
			hy_sr   <= {{7{oy_sm[31]}}, oy_sm} + {myr[53], myr[53:16]};
			dv_s[0] <= dv_in;
			for (int j = 0; j < QB; j++) begin
				dv_s[j+1] <= dv_nx[j];
			end
			// result register, all zero on a miss
			hit_q  <= !dv_s[QB].miss;
			kind_q <= !dv_s[QB].miss && cfg.src;
			dist_q <= dv_s[QB].miss ? '0 : dv_s[QB].dist_sat;
			ptx_q  <= dv_s[QB].miss ? '0 : dv_s[QB].px;
			pty_q  <= dv_s[QB].miss ? '0 : dv_s[QB].py;
			if (dv_s[QB].miss || dv_s[QB].rz) begin
				nx_q <= '0;
				ny_q <= '0;
			end else begin
				nx_q <= dv_s[QB].negx ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
				ny_q <= dv_s[QB].negy ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
			end
		end
	end

	assign res_zero = (dist_q == '0) && (ptx_q == '0) && (pty_q == '0) &&
		(nx_q == '0) && (ny_q == '0) && !kind_q;
	assign norm_ok  = (nx_q <= rci_pkg::NORM_ONE) && (nx_q >= -rci_pkg::NORM_ONE) &&
		(ny_q <= rci_pkg::NORM_ONE) && (ny_q >= -rci_pkg::NORM_ONE);

	`RCI_ASSERT(miss_is_zero, out_vld_q && !hit_q |-> res_zero, "miss result not cleared")
	`RCI_ASSERT(normal_range, out_vld_q && hit_q |-> norm_ok, "normal outside unit range")
	`RCI_ASSERT_NEXT(out_held, out_vld_q && !out_ready, out_vld_q && $stable(ptx_q), "stalled result changed")

endmodule

/* tb/tb_ray_circle_intersect_2d.sv */
module tb_ray_circle_intersect_2d;
	timeunit 1ns;
	timeprecision 1ps;

	// one result of the block as the scoreboard sees it
	typedef struct packed {
		logic               hit;
		logic [30:0]        distance;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic               kind;
	} hit_t;

	// one row of the directed table, with a hand-worked result where obvious
	typedef struct {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		bit                 known;
		hit_t               res;
	} ray_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // origin_x, origin_y, dir_x, dir_y, zero pad
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;   // distance, point_x, point_y, normal_x, normal_y, zero pad
	logic [1:0]   m_tuser;   // hit, hit_kind
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	// shadow copy of the circle registers
	longint          circ_cx;
	longint          circ_cy;
	longint unsigned circ_r;
	bit              circ_src;
	bit              circ_ign;

	hit_t     pending_hits[$];
	int       errors;
	int       send_idle_pct;
	int       recv_idle_pct;
	bit       hold_req;
	int       hold_left;
	int       quiet_cycles;
	ray_row_t rows[$];

	ray_circle_intersect_2d dut (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'h1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] sat32(longint x);
		if (x > 64'sh7fffffff)
			return 32'sh7fffffff;
		if (x < -64'sh80000000)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [17:0] clamp_unit(longint x);
		if (x > 65536)
			return rci_pkg::NORM_ONE;
		if (x < -65536)
			return -rci_pkg::NORM_ONE;
		return x[17:0];
	endfunction

	// geometric ray / circle intersection, exact in fixed point
	function automatic hit_t trace_ray(logic signed [31:0] ox_i, logic signed [31:0] oy_i,
			logic signed [17:0] dx_i, logic signed [17:0] dy_i);
		longint          ox, oy, dx, dy, ocx, ocy, adjq, perq, adj, len, hx, hy;
		longint unsigned ax, ay, r, pa, p, h;
		hit_t            o;
		o = '0;
		ox = ox_i;
		oy = oy_i;
		dx = dx_i;
		dy = dy_i;
		ocx = circ_cx - ox;
		ocy = circ_cy - oy;
		ax = (ocx < 0) ? -ocx : ocx;
		ay = (ocy < 0) ? -ocy : ocy;
		r = circ_r;
		if (circ_ign && circ_src)
			return o;
		// origin strictly inside
		if (ax < r && ay < r && ax * ax + ay * ay < r * r)
			return o;
		// centre behind or beside the ray
		adjq = dx * ocx + dy * ocy;
		if (adjq <= 0)
			return o;
		perq = dx * ocy - dy * ocx;
		pa = (perq < 0) ? -perq : perq;
		if (pa > (r << 16))
			return o;
		p = (pa + 32768) >> 16;
		if (p > r)
			p = r;
		h = int_sqrt((r - p) * (r + p));
		adj = (adjq + 32768) >>> 16;
		len = (adj > longint'(h)) ? adj - longint'(h) : 0;
		hx = ox + ((len * dx + 32768) >>> 16);
		hy = oy + ((len * dy + 32768) >>> 16);
		// zero radius leaves the normal at zero
		if (r != 0) begin
			o.nx = clamp_unit(((hx - circ_cx) * 65536) / longint'(r));
			o.ny = clamp_unit(((hy - circ_cy) * 65536) / longint'(r));
		end
		o.hit = 1'b1;
		o.distance = (len > 64'sh7fffffff) ? 31'h7fffffff : len[30:0];
		o.px = sat32(hx);
		o.py = sat32(hy);
		o.kind = circ_src;
		return o;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			rci_pkg::REG_CENTRE_X:  circ_cx = longint'($signed(val));
			rci_pkg::REG_CENTRE_Y:  circ_cy = longint'($signed(val));
			rci_pkg::REG_RADIUS:    circ_r = val[30:0];
			rci_pkg::REG_IS_SOURCE: circ_src = val[0];
			rci_pkg::REG_IGN_SRC:   circ_ign = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [30:0] r, bit src, bit ign);
		write_reg(rci_pkg::REG_CENTRE_X, cx);
		write_reg(rci_pkg::REG_CENTRE_Y, cy);
		write_reg(rci_pkg::REG_RADIUS, {1'b0, r});
		write_reg(rci_pkg::REG_IS_SOURCE, {31'd0, src});
		write_reg(rci_pkg::REG_IGN_SRC, {31'd0, ign});
	endtask

	// offer one ray; the expectation is queued on the transfer itself
	task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
			logic signed [17:0] dx, logic signed [17:0] dy, bit known, hit_t res);
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, dy, dx, oy, ox};
		do
			@(posedge clk);
		while (!s_tready);
		pending_hits.push_back(known ? res : trace_ray(ox, oy, dx, dy));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly rays aimed near the circle, the rest raw bit patterns
	task automatic send_random_ray();
		real                a, rr, span;
		longint             ox, oy;
		logic signed [31:0] rox, roy;
		logic signed [17:0] rdx, rdy;
		hit_t               none;
		none = '0;
		if ($urandom_range(99) < 70) begin
			rr = (circ_r == 0) ? 65536.0 : real'(circ_r);
			span = rr * ($urandom_range(400) / 100.0) + real'($urandom_range(65535));
			a = $urandom_range(62831) / 10000.0;
			ox = circ_cx + longint'(span * $cos(a));
			oy = circ_cy + longint'(span * $sin(a));
			rox = ox[31:0];
			roy = oy[31:0];
			// head back towards the centre with some spread
			a = a + 3.14159265 + (real'($urandom_range(2000)) - 1000.0) / 1500.0;
			rdx = 18'($rtoi($cos(a) * 65536.0));
			rdy = 18'($rtoi($sin(a) * 65536.0));
			if ($urandom_range(9) == 0)
				rdx = 18'($urandom);
		end else begin
			rox = $urandom;
			roy = $urandom;
			rdx = 18'($urandom);
			rdy = 18'($urandom);
		end
		send_ray(rox, roy, rdx, rdy, 1'b0, none);
	endtask

	function automatic void add_row(longint ox, longint oy, longint dx, longint dy,
			bit known, hit_t res);
		ray_row_t rw;
		rw.ox = ox[31:0];
		rw.oy = oy[31:0];
		rw.dx = dx[17:0];
		rw.dy = dy[17:0];
		rw.known = known;
		rw.res = res;
		rows.push_back(rw);
	endfunction

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			errors++;
		end
	endtask

	// receiver: random stalls, and a long hold-off when asked for
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		hit_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[30:0], m_tdata[62:31], m_tdata[94:63],
				m_tdata[112:95], m_tdata[130:113], m_tuser[1]};
			if (pending_hits.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				want = pending_hits.pop_front();
				check_field("hit", want.hit, got.hit);
				check_field("distance", want.distance, got.distance);
				check_field("point_x", want.px, got.px);
				check_field("point_y", want.py, got.py);
				check_field("normal_x", want.nx, got.nx);
				check_field("normal_y", want.ny, got.ny);
				check_field("hit_kind", want.kind, got.kind);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		hit_t none, h;
		none = '0;
		errors = 0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle_pct = 13;
		recv_idle_pct = 58;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rci_pkg::REG_CENTRE_X;
		cfg_data = '0;
		circ_cx = 0;
		circ_cy = 0;
		circ_r = rci_pkg::RADIUS_RST;
		circ_src = 1'b0;
		circ_ign = 1'b0;

		// directed rays against the reset circle (unit circle at the origin)
		add_row(0, 0, 65536, 0, 1'b1, none);               // origin at the centre
		h = '0;
		h.hit = 1'b1; h.distance = 31'd65536; h.px = -32'sd65536; h.nx = -rci_pkg::NORM_ONE;
		add_row(-131072, 0, 65536, 0, 1'b1, h);            // straight on from the left
		add_row(131072, 0, 65536, 0, 1'b1, none);          // circle behind
		add_row(-131072, 196608, 65536, 0, 1'b1, none);    // passes clear above
		add_row(-131072, 65536, 65536, 0, 1'b0, none);     // tangent
		add_row(0, -131072, 0, 65536, 1'b0, none);
		add_row(0, 131072, 0, -65536, 1'b0, none);
		add_row(-131072, 0, 131071, 0, 1'b0, none);        // direction field extremes
		add_row(131072, 0, -131072, 0, 1'b0, none);
		add_row(-131072, -131072, 46341, 46341, 1'b0, none);
		add_row(-2147483648, 0, 65536, 0, 1'b0, none);     // origin field extremes
		add_row(2147483647, -2147483648, -46341, 46341, 1'b0, none);
		add_row(2147483647, 2147483647, -131072, -131072, 1'b0, none);
		add_row(-2147483648, -2147483648, 131071, 131071, 1'b0, none);
		add_row(65536, 0, 65536, 0, 1'b0, none);           // origin on the surface

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_ray(rows[i].ox, rows[i].oy, rows[i].dx, rows[i].dy, rows[i].known, rows[i].res);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 58 : 0;
			recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 13 : 0;
			case (ph)
				0: set_circle(32'($urandom_range(200 << 16)) - (100 << 16),
					32'($urandom_range(200 << 16)) - (100 << 16),
					31'($urandom_range(8 << 16, 1 << 16)), 1'b1, 1'b0);
				1: set_circle(32'($urandom_range(20 << 16)), 32'h0, 31'd0, 1'b0, 1'b1);
				2: set_circle(32'h0, 32'h0, 31'(3 << 16), 1'b1, 1'b1);
				3: set_circle(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b0, 1'b0);
				4: set_circle($urandom, $urandom, 31'($urandom), 1'($urandom), 1'b0);
				default: set_circle(32'h0, 32'h0, rci_pkg::RADIUS_RST, 1'b0, 1'b0);
			endcase
			// long receiver hold-off so the pipeline backs up into the input
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < 80; k++) begin
				// one pause mid-phase until every result is back
				if (ph == 1 && k == 40)
					drain();
				send_random_ray();
			end
			drain();
		end

		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
